// File: hw/rtl/prt_pkg.sv
// Shared types, constants and helpers for the PT1000 resistance-to-temperature block.
// Used by the multiplier, divider, datapath, controller and top level. No dependencies.
`timescale 1ns / 1ps

package prt_pkg;

   localparam int RES_W  = 29;
   localparam int TEMP_W = 27;
   localparam int COEF_W = 32;

   typedef logic signed [63:0] word_type;

   localparam word_type T_MIN       = -64'sd13107200;
   localparam word_type T_MAX       = 64'sd55705600;
   localparam word_type STEP_LIMIT  = 64'sd66;
   localparam word_type HUNDRED_Q16 = 64'sd6553600;
   localparam word_type K300        = 64'sd300;

   localparam logic [RES_W-1:0]         R0_RESET = 29'd65536000;
   localparam logic signed [COEF_W-1:0] A_RESET  = 32'sd16786021;
   localparam logic signed [COEF_W-1:0] B_RESET  = -32'sd162551799;
   localparam logic signed [COEF_W-1:0] C_RESET  = -32'sd77162730;

   typedef enum logic [1:0] {
      REG_R0 = 2'd0,
      REG_A  = 2'd1,
      REG_B  = 2'd2,
      REG_C  = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      SRC_R0, SRC_A, SRC_B, SRC_C, SRC_T, SRC_T2, SRC_T3, SRC_X,
      SRC_P, SRC_D, SRC_TWO_T, SRC_T_M100, SRC_K300, SRC_CUBIC_DIFF
   } src_type;

   typedef enum logic [2:0] {
      DST_T2, DST_T3, DST_X, DST_P, DST_D, DST_F, DST_DF
   } dst_type;

   typedef enum logic [2:0] {
      BASE_ZERO, BASE_P, BASE_D, BASE_A, BASE_R0_MINUS_R
   } base_type;

   typedef enum logic [2:0] {
      SH_0, SH_16, SH_32, SH_48, SH_64
   } shift_type;

   typedef enum logic {
      NUM_INIT, NUM_STEP
   } num_type;

   typedef struct packed {
      logic      start_mul;
      logic      start_div;
      src_type   mul_a;
      src_type   mul_b;
      shift_type mul_shift;
      dst_type   mul_dst;
      base_type  mul_base;
      num_type   div_num;
      logic      load;
      logic      clear_t;
      logic      init_clamp;
      logic      update;
      logic      emit;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic den_zero;
      logic t_neg;
      logic step_small;
      logic out_busy;
   } status_type;

   function automatic word_type clamp_temp(input word_type v);
      word_type r;
      r = v;
      if (v < T_MIN) r = T_MIN;
      else if (v > T_MAX) r = T_MAX;
      return r;
   endfunction

endpackage

// File: hw/rtl/pt1000_resistance_to_temperature.sv
// Computes a linear estimate, then up to MAX_STEPS Newton steps; a step below 0 C adds the
// cubic terms. All products go through the shared multiplier and all quotients through the
// shared divider.
// One item is processed at a time; a new transfer is taken only once the previous result
// is registered, which waits while the output is stalled. Reset is synchronous and active
// high; it restores the default coefficients and empties the result register.
`timescale 1ns / 1ps

module pt1000_resistance_to_temperature #(
   parameter int MAX_STEPS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [28:0] resistance
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [26:0] temperature
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import prt_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic signed [TEMP_W-1:0] temperature;

   prt_ctrl #(
      .MAX_STEPS (MAX_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   prt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_resistance  (req_tdata[RES_W-1:0]),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_temperature (temperature)
   );

   assign rsp_tdata = {5'd0, temperature};

endmodule

// File: hw/rtl/prt_mul.sv
// Sequential signed multiplier with truncating right shift, 16 multiplier bits per cycle.
// Depends on prt_pkg.
`timescale 1ns / 1ps

module prt_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  prt_pkg::word_type   a,
   input  prt_pkg::word_type   b,
   input  prt_pkg::shift_type  shift,
   output logic                done,
   output prt_pkg::word_type   product
);
   import prt_pkg::*;

   logic [63:0]  ua_ff, ub_ff;
   logic         neg_ff;
   shift_type    shift_ff;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [15:0]  chunk;
   logic [79:0]  partial;
   logic [127:0] aligned;
   logic [63:0]  mag;
   logic [63:0]  ua_in, ub_in;

   assign ua_in = a[63] ? 64'(-a) : 64'(a);
   assign ub_in = b[63] ? 64'(-b) : 64'(b);

   always_comb begin
      case (cnt_ff)
         2'd0: chunk = ub_ff[15:0];
         2'd1: chunk = ub_ff[31:16];
         2'd2: chunk = ub_ff[47:32];
         default: chunk = ub_ff[63:48];
      endcase
      partial = 80'(ua_ff) * 80'(chunk);
      aligned = {48'd0, partial} << {cnt_ff, 4'd0};
      acc_in  = acc_ff + aligned;
   end

   always_comb begin
      case (shift_ff)
         SH_0:    mag = acc_ff[63:0];
         SH_16:   mag = acc_ff[79:16];
         SH_32:   mag = acc_ff[95:32];
         SH_48:   mag = acc_ff[111:48];
         SH_64:   mag = acc_ff[127:64];
         default: mag = acc_ff[63:0];
      endcase
   end

   assign product = neg_ff ? -$signed(mag) : $signed(mag);
   assign done    = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 2'd3);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == 2'd3)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ua_ff    <= ua_in;
         ub_ff    <= ub_in;
         neg_ff   <= a[63] ^ b[63];
         shift_ff <= shift;
         acc_ff   <= '0;
         cnt_ff   <= 2'd0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

endmodule

// File: hw/rtl/prt_div.sv
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on prt_pkg.
`timescale 1ns / 1ps

module prt_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  prt_pkg::word_type  num,
   input  prt_pkg::word_type  den,
   output logic               done,
   output prt_pkg::word_type  quotient
);
   import prt_pkg::*;

   logic [63:0] un_ff, ud_ff;
   logic [64:0] rem_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff, busy_ff, done_ff;
   logic [64:0] rem_sh, rem_in;
   logic        ge;

   always_comb begin
      rem_sh = {rem_ff[63:0], un_ff[63]};
      ge     = rem_sh >= {1'b0, ud_ff};
      rem_in = ge ? rem_sh - {1'b0, ud_ff} : rem_sh;
   end

   assign quotient = neg_ff ? -$signed(un_ff) : $signed(un_ff);
   assign done     = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 6'd63);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == 6'd63)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         un_ff  <= num[63] ? 64'(-num) : 64'(num);
         ud_ff  <= den[63] ? 64'(-den) : 64'(den);
         rem_ff <= '0;
         cnt_ff <= 6'd0;
         neg_ff <= num[63] ^ den[63];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         un_ff  <= {un_ff[62:0], ge};
         cnt_ff <= cnt_ff + 6'd1;
      end
   end

endmodule

// File: hw/rtl/prt_datapath.sv
// Datapath: coefficient registers, working registers, shared multiplier and divider,
// and the result register. Depends on prt_pkg, prt_mul and prt_div.
`timescale 1ns / 1ps

module prt_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [prt_pkg::COEF_W-1:0]       csr_wdata,
   input  logic [prt_pkg::RES_W-1:0]        req_resistance,
   input  prt_pkg::cmd_type                 cmd,
   output prt_pkg::status_type              status,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [prt_pkg::TEMP_W-1:0] rsp_temperature
);
   import prt_pkg::*;

   logic [RES_W-1:0]         r0_ff;
   logic signed [COEF_W-1:0] a_ff, b_ff, c_ff;
   logic [RES_W-1:0]         r_ff;
   word_type t_ff, t2_ff, t3_ff, x_ff, p_ff, d_ff, f_ff, df_ff, q_ff;
   dst_type  mdst_ff;
   base_type mbase_ff;
   logic     rsp_valid_ff;
   logic signed [TEMP_W-1:0] rsp_temp_ff;

   word_type r0_w, r_w, a_w, b_w, c_w;
   word_type op_a, op_b, base_val, mul_y, mul_val, div_num, div_q;
   logic     mul_done, div_done;

   assign r0_w = word_type'({35'd0, r0_ff});
   assign r_w  = word_type'({35'd0, r_ff});
   assign a_w  = word_type'(a_ff);
   assign b_w  = word_type'(b_ff);
   assign c_w  = word_type'(c_ff);

   function automatic word_type pick(input src_type s, input word_type r0v, input word_type av,
                                     input word_type bv, input word_type cv, input word_type tv,
                                     input word_type t2v, input word_type t3v,
                                     input word_type xv, input word_type pv,
                                     input word_type dv);
      word_type v;
      case (s)
         SRC_R0:         v = r0v;
         SRC_A:          v = av;
         SRC_B:          v = bv;
         SRC_C:          v = cv;
         SRC_T:          v = tv;
         SRC_T2:         v = t2v;
         SRC_T3:         v = t3v;
         SRC_X:          v = xv;
         SRC_P:          v = pv;
         SRC_D:          v = dv;
         SRC_TWO_T:      v = tv <<< 1;
         SRC_T_M100:     v = tv - HUNDRED_Q16;
         SRC_K300:       v = K300;
         SRC_CUBIC_DIFF: v = (t3v <<< 2) - xv;
         default:        v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      op_a = pick(cmd.mul_a, r0_w, a_w, b_w, c_w, t_ff, t2_ff, t3_ff, x_ff, p_ff, d_ff);
      op_b = pick(cmd.mul_b, r0_w, a_w, b_w, c_w, t_ff, t2_ff, t3_ff, x_ff, p_ff, d_ff);
      case (mbase_ff)
         BASE_ZERO:       base_val = '0;
         BASE_P:          base_val = p_ff;
         BASE_D:          base_val = d_ff;
         BASE_A:          base_val = a_w;
         BASE_R0_MINUS_R: base_val = r0_w - r_w;
         default:         base_val = '0;
      endcase
      mul_val = base_val + mul_y;
      case (cmd.div_num)
         NUM_INIT: div_num = (r_w - r0_w) <<< 16;
         NUM_STEP: div_num = f_ff <<< 16;
         default:  div_num = '0;
      endcase
   end

   prt_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.start_mul),
      .a       (op_a),
      .b       (op_b),
      .shift   (cmd.mul_shift),
      .done    (mul_done),
      .product (mul_y)
   );

   prt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .num      (div_num),
      .den      (df_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_ff <= R0_RESET;
         a_ff  <= A_RESET;
         b_ff  <= B_RESET;
         c_ff  <= C_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_R0:  r0_ff <= csr_wdata[RES_W-1:0];
            REG_A:   a_ff  <= csr_wdata;
            REG_B:   b_ff  <= csr_wdata;
            REG_C:   c_ff  <= csr_wdata;
            default: r0_ff <= r0_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) r_ff <= req_resistance;
      if (cmd.start_mul) begin
         mdst_ff  <= cmd.mul_dst;
         mbase_ff <= cmd.mul_base;
      end
      if (mul_done) begin
         case (mdst_ff)
            DST_T2:  t2_ff <= mul_val;
            DST_T3:  t3_ff <= mul_val;
            DST_X:   x_ff  <= mul_val;
            DST_P:   p_ff  <= mul_val;
            DST_D:   d_ff  <= mul_val;
            DST_F:   f_ff  <= mul_val;
            DST_DF:  df_ff <= mul_val;
            default: x_ff  <= mul_val;
         endcase
      end
      if (div_done) q_ff <= div_q;
      if (cmd.clear_t) begin
         t_ff <= '0;
      end else if (cmd.init_clamp) begin
         t_ff <= clamp_temp(q_ff);
      end else if (cmd.update) begin
         t_ff <= clamp_temp(t_ff - q_ff);
      end
      if (cmd.emit) rsp_temp_ff <= t_ff[TEMP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.mul_done   = mul_done;
   assign status.div_done   = div_done;
   assign status.den_zero   = (df_ff == '0);
   assign status.t_neg      = t_ff[63];
   assign status.step_small = (q_ff < STEP_LIMIT) && (q_ff > -STEP_LIMIT);
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temp_ff;

endmodule

// File: hw/rtl/prt_ctrl.sv
// Controller state machine that sequences the linear estimate and the Newton steps.
// Depends on prt_pkg; drives the datapath through the command and status structs.
`timescale 1ns / 1ps

module prt_ctrl #(
   parameter int MAX_STEPS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  prt_pkg::status_type  status,
   output prt_pkg::cmd_type     cmd
);
   import prt_pkg::*;

   localparam int CW = $clog2(MAX_STEPS + 1);

   typedef enum logic [17:0] {
      ST_IDLE       = 18'h00001,
      ST_DEN        = 18'h00002,
      ST_INIT_DIV   = 18'h00004,
      ST_INIT_CLAMP = 18'h00008,
      ST_SQ         = 18'h00010,
      ST_AT         = 18'h00020,
      ST_BT2        = 18'h00040,
      ST_BD         = 18'h00080,
      ST_T3         = 18'h00100,
      ST_TQ         = 18'h00200,
      ST_CQ         = 18'h00400,
      ST_K300       = 18'h00800,
      ST_CD         = 18'h01000,
      ST_FV         = 18'h02000,
      ST_DFV        = 18'h04000,
      ST_STEP_DIV   = 18'h08000,
      ST_UPDATE     = 18'h10000,
      ST_DONE       = 18'h20000
   } state_type;

   state_type     state_ff, state_in, mul_next;
   logic          launched_ff, launched_in;
   logic [CW-1:0] step_ff, step_in;
   logic          is_mul;

   always_comb begin
      cmd           = '0;
      cmd.mul_a     = SRC_R0;
      cmd.mul_b     = SRC_A;
      cmd.mul_shift = SH_0;
      cmd.mul_dst   = DST_X;
      cmd.mul_base  = BASE_ZERO;
      cmd.div_num   = NUM_INIT;
      state_in      = state_ff;
      launched_in   = launched_ff;
      step_in       = step_ff;
      is_mul        = 1'b0;
      mul_next      = state_ff;
      req_tready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            is_mul = 1'b1; mul_next = ST_INIT_DIV;
            cmd.mul_a = SRC_R0; cmd.mul_b = SRC_A; cmd.mul_shift = SH_32;
            cmd.mul_dst = DST_DF;
         end
         ST_INIT_DIV: begin
            cmd.div_num = NUM_INIT;
            if (!launched_ff) begin
               if (status.den_zero) begin
                  cmd.clear_t = 1'b1;
                  state_in    = ST_SQ;
               end else begin
                  cmd.start_div = 1'b1;
                  launched_in   = 1'b1;
               end
            end else if (status.div_done) begin
               launched_in = 1'b0;
               state_in    = ST_INIT_CLAMP;
            end
         end
         ST_INIT_CLAMP: begin
            cmd.init_clamp = 1'b1;
            state_in       = ST_SQ;
         end
         ST_SQ: begin
            is_mul = 1'b1; mul_next = ST_AT;
            cmd.mul_a = SRC_T; cmd.mul_b = SRC_T; cmd.mul_dst = DST_T2;
         end
         ST_AT: begin
            is_mul = 1'b1; mul_next = ST_BT2;
            cmd.mul_a = SRC_A; cmd.mul_b = SRC_T; cmd.mul_shift = SH_16;
            cmd.mul_dst = DST_P;
         end
         ST_BT2: begin
            is_mul = 1'b1; mul_next = ST_BD;
            cmd.mul_a = SRC_B; cmd.mul_b = SRC_T2; cmd.mul_shift = SH_48;
            cmd.mul_dst = DST_P; cmd.mul_base = BASE_P;
         end
         ST_BD: begin
            is_mul = 1'b1; mul_next = status.t_neg ? ST_T3 : ST_FV;
            cmd.mul_a = SRC_B; cmd.mul_b = SRC_TWO_T; cmd.mul_shift = SH_32;
            cmd.mul_dst = DST_D; cmd.mul_base = BASE_A;
         end
         ST_T3: begin
            is_mul = 1'b1; mul_next = ST_TQ;
            cmd.mul_a = SRC_T2; cmd.mul_b = SRC_T; cmd.mul_shift = SH_16;
            cmd.mul_dst = DST_T3;
         end
         ST_TQ: begin
            is_mul = 1'b1; mul_next = ST_CQ;
            cmd.mul_a = SRC_T3; cmd.mul_b = SRC_T_M100; cmd.mul_shift = SH_32;
            cmd.mul_dst = DST_X;
         end
         ST_CQ: begin
            is_mul = 1'b1; mul_next = ST_K300;
            cmd.mul_a = SRC_C; cmd.mul_b = SRC_X; cmd.mul_shift = SH_48;
            cmd.mul_dst = DST_P; cmd.mul_base = BASE_P;
         end
         ST_K300: begin
            is_mul = 1'b1; mul_next = ST_CD;
            cmd.mul_a = SRC_T2; cmd.mul_b = SRC_K300; cmd.mul_dst = DST_X;
         end
         ST_CD: begin
            is_mul = 1'b1; mul_next = ST_FV;
            cmd.mul_a = SRC_C; cmd.mul_b = SRC_CUBIC_DIFF; cmd.mul_shift = SH_64;
            cmd.mul_dst = DST_D; cmd.mul_base = BASE_D;
         end
         ST_FV: begin
            is_mul = 1'b1; mul_next = ST_DFV;
            cmd.mul_a = SRC_R0; cmd.mul_b = SRC_P; cmd.mul_shift = SH_32;
            cmd.mul_dst = DST_F; cmd.mul_base = BASE_R0_MINUS_R;
         end
         ST_DFV: begin
            is_mul = 1'b1; mul_next = ST_STEP_DIV;
            cmd.mul_a = SRC_R0; cmd.mul_b = SRC_D; cmd.mul_shift = SH_32;
            cmd.mul_dst = DST_DF;
         end
         ST_STEP_DIV: begin
            cmd.div_num = NUM_STEP;
            if (!launched_ff) begin
               if (status.den_zero) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.start_div = 1'b1;
                  launched_in   = 1'b1;
               end
            end else if (status.div_done) begin
               launched_in = 1'b0;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.step_small || (step_ff == CW'(MAX_STEPS - 1))) begin
               state_in = ST_DONE;
            end else begin
               step_in  = step_ff + CW'(1);
               state_in = ST_SQ;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (is_mul) begin
         if (!launched_ff) begin
            cmd.start_mul = 1'b1;
            launched_in   = 1'b1;
         end else if (status.mul_done) begin
            launched_in = 1'b0;
            state_in    = mul_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         launched_ff <= 1'b0;
         step_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
         step_ff     <= step_in;
      end
   end

`ifndef SYNTHESIS
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.start_mul && cmd.start_div))
      else $error("multiplier and divider started together");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff < CW'(MAX_STEPS))
      else $error("Newton step count out of range");
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      (status.mul_done || status.div_done) |-> launched_ff)
      else $error("arithmetic unit finished with no operation pending");
   a_load_next: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_DEN) && !req_tready)
      else $error("accepted transfer did not start the computation");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the PT1000 resistance-to-temperature block: directed, register and random tests.
// It predicts each temperature with its own Newton solver and checks every transfer in order.
// Depends on prt_pkg and pt1000_resistance_to_temperature.
`timescale 1ns / 1ps

module tb_top;
   import prt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [28:0] resistance
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [26:0] temperature
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   logic [RES_W-1:0]         nominal_r0;
   logic signed [COEF_W-1:0] coef_a, coef_b, coef_c;
   logic [TEMP_W-1:0]        expected_temps[$];
   int  failures = 0;
   bit  quiet = 1'b0;

   pt1000_resistance_to_temperature dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #100ms;
      $display("Some tests failed");
      $finish;
   end

   // (x * y) >> sh on the magnitudes, truncated toward zero, saturating at 63 bits.
   function automatic longint scaled_product(input longint x, input longint y, input int sh);
      logic signed [127:0] xs, ys;
      logic [127:0] p;
      bit neg;
      xs = x;
      ys = y;
      neg = (x < 0) != (y < 0);
      if (xs < 0) xs = -xs;
      if (ys < 0) ys = -ys;
      p = (xs * ys) >> sh;
      if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic longint clamp_t(input longint t);
      if (t < T_MIN) return T_MIN;
      if (t > T_MAX) return T_MAX;
      return t;
   endfunction

   function automatic logic [TEMP_W-1:0] solve_temperature(input logic [RES_W-1:0] res);
      longint r, r0, a, b, c, t, den, t2, t3, q, p, d, f, df, dt;
      r = res;
      r0 = nominal_r0;
      a = coef_a;
      b = coef_b;
      c = coef_c;
      t = 0;
      den = scaled_product(r0, a, 32);
      if (den != 0) t = ((r - r0) * 65536) / den;
      t = clamp_t(t);
      for (int i = 0; i < 10; i++) begin
         t2 = t * t;
         p = scaled_product(a, t, 16) + scaled_product(b, t2, 48);
         d = a + scaled_product(b, 2 * t, 32);
         dt = 0;
         if (t < 0) begin
            t3 = scaled_product(t2, t, 16);
            q = scaled_product(t3, t - HUNDRED_Q16, 32);
            p += scaled_product(c, q, 48);
            d += scaled_product(c, 4 * t3 - 300 * t2, 64);
         end
         f = r0 + scaled_product(r0, p, 32) - r;
         df = scaled_product(r0, d, 32);
         if (df != 0) dt = (f * 65536) / df;
         t = clamp_t(t - dt);
         if (dt < STEP_LIMIT && dt > -STEP_LIMIT) break;
      end
      return t[TEMP_W-1:0];
   endfunction

   task automatic send_resistance(input logic [RES_W-1:0] res);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b0, res};
      do @(posedge clock); while (!req_tready);
      expected_temps.push_back(solve_temperature(res));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_temps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_coefficients(input logic [RES_W-1:0] r0, input logic [31:0] a,
                                   input logic [31:0] b, input logic [31:0] c);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= REG_R0; csr_wdata <= {3'b0, r0}; @(posedge clock);
      csr_index <= REG_A;  csr_wdata <= a;          @(posedge clock);
      csr_index <= REG_B;  csr_wdata <= b;          @(posedge clock);
      csr_index <= REG_C;  csr_wdata <= c;          @(posedge clock);
      csr_we <= 1'b0;
      nominal_r0 = r0;
      coef_a = a;
      coef_b = b;
      coef_c = c;
   endtask

   function automatic logic [RES_W-1:0] sensor_reading();
      if ($urandom_range(0, 4) == 0) return RES_W'($urandom);
      return RES_W'($urandom_range(11141120, 262144000));
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_temps.size() == 0) begin
            $display("%t: unexpected transfer, actual %0d", $realtime,
                     $signed(rsp_tdata[TEMP_W-1:0]));
            failures++;
         end else begin
            if (rsp_tdata[TEMP_W-1:0] !== expected_temps[0]) begin
               $display("%t: temperature expected %0d, actual %0d", $realtime,
                        $signed(expected_temps[0]), $signed(rsp_tdata[TEMP_W-1:0]));
               failures++;
            end
            void'(expected_temps.pop_front());
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_default_curve();
      logic [RES_W-1:0] points[] = '{0, 29'h1FFFFFFF, R0_RESET, 12124160, 11141120,
                                     257802240, 262144000, 65536001, 65535999, 72089600,
                                     52428800, 131072000};
      foreach (points[i]) send_resistance(points[i]);
   endtask

   task automatic test_coefficient_extremes();
      set_coefficients(0, A_RESET, B_RESET, C_RESET);
      send_resistance(65536000);
      send_resistance(0);
      set_coefficients(R0_RESET, 0, 0, 0);
      send_resistance(70000000);
      set_coefficients(29'h1FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_resistance(29'h1FFFFFFF);
      send_resistance(1000);
      set_coefficients(29'h1FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000);
      send_resistance(29'h1FFFFFFF);
      send_resistance(0);
      set_coefficients(R0_RESET, A_RESET, 0, 32'h7FFFFFFF);
      send_resistance(20000000);
      send_resistance(100000000);
   endtask

   task automatic test_random_readings();
      set_coefficients(R0_RESET, A_RESET, B_RESET, C_RESET);
      repeat (200) send_resistance(sensor_reading());
      repeat (4) begin
         set_coefficients(RES_W'($urandom_range(6553600, 131072000)),
                          $urandom_range(12000000, 20000000),
                          -$urandom_range(100000000, 220000000),
                          $urandom_range(0, 1) ? $urandom : -$urandom_range(0, 90000000));
         repeat (30) send_resistance(sensor_reading());
      end
      set_coefficients(R0_RESET, A_RESET, B_RESET, C_RESET);
      quiet = 1'b1;
      repeat (60) send_resistance(sensor_reading());
   endtask

   initial begin
      nominal_r0 = R0_RESET;
      coef_a = A_RESET;
      coef_b = B_RESET;
      coef_c = C_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_curve();
      test_coefficient_extremes();
      test_random_readings();
      wait_idle();
      if (failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/prt_pkg.sv
hw/rtl/prt_mul.sv
hw/rtl/prt_div.sv
hw/rtl/prt_datapath.sv
hw/rtl/prt_ctrl.sv
hw/rtl/pt1000_resistance_to_temperature.sv
tb/sv/tb_top.sv
